// ===== rtl/tlsa_pkg.sv =====
// Shared types, constants and the quad swizzle for the tiled-to-linear store addresser.
`timescale 1ns / 1ps
package tlsa_pkg;

   localparam int TILE_DIM        = 8;
   localparam int BYTES_PER_PIXEL = 4;
   localparam int TILE_BYTES      = TILE_DIM * TILE_DIM * BYTES_PER_PIXEL;

   localparam int COORD_WIDTH  = 11;
   localparam int SIZE_WIDTH   = 4;
   localparam int PITCH_WIDTH  = 19;
   localparam int HEIGHT_WIDTH = 15;
   localparam int ADDR_WIDTH   = 32;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 19;
   localparam int POS_WIDTH    = $clog2(TILE_DIM);
   localparam int PXY_WIDTH    = COORD_WIDTH + POS_WIDTH;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_DEST_ROW_PITCH  = 2'd0,
      CSR_IMAGE_HEIGHT    = 2'd1,
      CSR_FLIP_ROWS       = 2'd2,
      CSR_TILE_ROW_BYTES  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic base;
      logic step;
   } dp_cmd_type;

   typedef struct packed {
      logic empty_req;
      logic out_free;
      logic at_last;
   } dp_status_type;

   // 2x2 quad swizzle of a pixel position inside a tile, in bytes
   function automatic logic [7:0] swizzle_offset(input logic [POS_WIDTH-1:0] col,
                                                 input logic [POS_WIDTH-1:0] row);
      return {row[2], row[1], col[2], col[1], row[0], col[0], 2'b00};
   endfunction

endpackage

// ===== rtl/tiled_to_linear_store_addresser.sv =====
// Top level of the tiled-to-linear store addresser: sequencer plus datapath.
//
//   channel  direction  handshake          word
//   req_     in         valid / stall      tile_col, tile_row, width_px, height_px
//   rsp_     out        valid / stall      source_offset, dest_offset, last_pixel
//   csr_     in         valid / ready      index, wdata
//
// A command runs through three setup steps (latch, multiply, base add), then emits one address
// pair per cycle while rsp_ does not stall, up to 64 for a full tile.
// Commands with zero width or height are taken without any setup step and produce nothing.
// A stalled rsp_ holds the output register and pauses the pixel walk.
// Reset is synchronous and restores the register defaults.
`timescale 1ns / 1ps
module tiled_to_linear_store_addresser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [tlsa_pkg::COORD_WIDTH-1:0]      req_tile_col,
   input  logic [tlsa_pkg::COORD_WIDTH-1:0]      req_tile_row,
   input  logic [tlsa_pkg::SIZE_WIDTH-1:0]       req_width_px,
   input  logic [tlsa_pkg::SIZE_WIDTH-1:0]       req_height_px,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tlsa_pkg::ADDR_WIDTH-1:0]       rsp_source_offset,
   output logic [tlsa_pkg::ADDR_WIDTH-1:0]       rsp_dest_offset,
   output logic                                  rsp_last_pixel,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tlsa_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [tlsa_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import tlsa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   tlsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tlsa_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_tile_col      (req_tile_col),
      .req_tile_row      (req_tile_row),
      .req_width_px      (req_width_px),
      .req_height_px     (req_height_px),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_source_offset (rsp_source_offset),
      .rsp_dest_offset   (rsp_dest_offset),
      .rsp_last_pixel    (rsp_last_pixel),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// ===== rtl/tlsa_ctrl.sv =====
// Sequencer for the tiled-to-linear store addresser: setup steps, then one pixel per step.
`timescale 1ns / 1ps
module tlsa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tlsa_pkg::dp_status_type status,
   output tlsa_pkg::dp_cmd_type    cmd
);
   import tlsa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_BASE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.empty_req) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            cmd.base = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.at_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== rtl/tlsa_dp.sv =====
// Datapath: config registers, base address math, pixel counters and the output word register.
`timescale 1ns / 1ps
module tlsa_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [tlsa_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [tlsa_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  logic [tlsa_pkg::COORD_WIDTH-1:0]      req_tile_col,
   input  logic [tlsa_pkg::COORD_WIDTH-1:0]      req_tile_row,
   input  logic [tlsa_pkg::SIZE_WIDTH-1:0]       req_width_px,
   input  logic [tlsa_pkg::SIZE_WIDTH-1:0]       req_height_px,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tlsa_pkg::ADDR_WIDTH-1:0]       rsp_source_offset,
   output logic [tlsa_pkg::ADDR_WIDTH-1:0]       rsp_dest_offset,
   output logic                                  rsp_last_pixel,
   input  tlsa_pkg::dp_cmd_type                  cmd,
   output tlsa_pkg::dp_status_type               status
);
   import tlsa_pkg::*;

   logic [PITCH_WIDTH-1:0]  pitch_ff;
   logic [HEIGHT_WIDTH-1:0] height_ff;
   logic                    flip_ff;
   logic [PITCH_WIDTH-1:0]  row_bytes_ff;

   logic [COORD_WIDTH-1:0]  tcol_ff;
   logic [PXY_WIDTH-1:0]    px_y_ff;
   logic [ADDR_WIDTH-1:0]   start_row_ff;
   logic [ADDR_WIDTH-1:0]   step_ff;
   logic [POS_WIDTH-1:0]    last_col_ff, last_row_ff;
   logic [ADDR_WIDTH-1:0]   src_prod_ff, dst_prod_ff;
   logic [ADDR_WIDTH-1:0]   src_base_ff, rstart_ff;
   logic [POS_WIDTH-1:0]    col_ff, row_ff;

   logic [ADDR_WIDTH-1:0]   src_ff, dst_ff;
   logic                    last_ff, valid_ff;

   logic [SIZE_WIDTH-1:0]   w_sat, h_sat;
   logic [PXY_WIDTH-1:0]    px_y_in;
   logic                    col_end;

   always_comb begin
      w_sat   = (req_width_px > SIZE_WIDTH'(TILE_DIM)) ? SIZE_WIDTH'(TILE_DIM) : req_width_px;
      h_sat   = (req_height_px > SIZE_WIDTH'(TILE_DIM)) ? SIZE_WIDTH'(TILE_DIM) : req_height_px;
      px_y_in = {req_tile_row, {POS_WIDTH{1'b0}}};
      col_end = (col_ff == last_col_ff);
   end

   assign status.empty_req = (req_width_px == '0) || (req_height_px == '0);
   assign status.out_free  = !valid_ff || !rsp_stall;
   assign status.at_last   = col_end && (row_ff == last_row_ff);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff     <= '0;
         height_ff    <= HEIGHT_WIDTH'(1);
         flip_ff      <= 1'b0;
         row_bytes_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DEST_ROW_PITCH: pitch_ff     <= csr_wdata[PITCH_WIDTH-1:0];
            CSR_IMAGE_HEIGHT:   height_ff    <= csr_wdata[HEIGHT_WIDTH-1:0];
            CSR_FLIP_ROWS:      flip_ff      <= csr_wdata[0];
            CSR_TILE_ROW_BYTES: row_bytes_ff <= csr_wdata[PITCH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // command setup, products, bases and pixel walk
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tcol_ff     <= req_tile_col;
         px_y_ff     <= px_y_in;
         last_col_ff <= POS_WIDTH'(w_sat - SIZE_WIDTH'(1));
         last_row_ff <= POS_WIDTH'(h_sat - SIZE_WIDTH'(1));
         if (flip_ff) begin
            start_row_ff <= ADDR_WIDTH'(height_ff) - ADDR_WIDTH'(px_y_in) - ADDR_WIDTH'(1);
            step_ff      <= ADDR_WIDTH'(0) - ADDR_WIDTH'(pitch_ff);
         end else begin
            start_row_ff <= ADDR_WIDTH'(px_y_in);
            step_ff      <= ADDR_WIDTH'(pitch_ff);
         end
      end
      if (cmd.mul) begin
         src_prod_ff <= ADDR_WIDTH'(ADDR_WIDTH'(px_y_ff) * ADDR_WIDTH'(row_bytes_ff));
         dst_prod_ff <= ADDR_WIDTH'(start_row_ff * ADDR_WIDTH'(pitch_ff));
      end
      if (cmd.base) begin
         src_base_ff <= src_prod_ff + ADDR_WIDTH'(ADDR_WIDTH'(tcol_ff) * TILE_BYTES);
         rstart_ff   <= dst_prod_ff
                        + ADDR_WIDTH'(ADDR_WIDTH'(tcol_ff) * (TILE_DIM * BYTES_PER_PIXEL));
         col_ff      <= '0;
         row_ff      <= '0;
      end
      if (cmd.step) begin
         src_ff  <= src_base_ff + ADDR_WIDTH'(swizzle_offset(col_ff, row_ff));
         dst_ff  <= rstart_ff + ADDR_WIDTH'(ADDR_WIDTH'(col_ff) * BYTES_PER_PIXEL);
         last_ff <= status.at_last;
         if (col_end) begin
            col_ff    <= '0;
            row_ff    <= row_ff + POS_WIDTH'(1);
            rstart_ff <= rstart_ff + step_ff;
         end else begin
            col_ff <= col_ff + POS_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.step) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_source_offset = src_ff;
   assign rsp_dest_offset   = dst_ff;
   assign rsp_last_pixel    = last_ff;

endmodule
